>>> src/abt_pkg.sv
// ----------------------------------------------------------------------------
// abt_pkg: shared constants and types of the adaptive beat tracker
// Register indexes, reset values and the arithmetic step codes.
// ----------------------------------------------------------------------------
`default_nettype none

package abt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_WEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE   = 3'd5;

  localparam logic [6:0]  RST_HISTORY_LEN  = 7'd32;
  localparam logic [15:0] RST_THRESH_GAIN  = 16'd6144;
  localparam logic [15:0] RST_DEV_WEIGHT   = 16'd4096;
  localparam logic [11:0] RST_MIN_INTERVAL = 12'd10;
  localparam logic [15:0] RST_ENV_STEP     = 16'd4096;
  localparam logic [15:0] RST_FRAME_RATE   = 16'd11025;

  localparam logic [11:0] FRAMES_MAX    = 12'hFFF;
  localparam int          MIN_INTERVALS = 5;

  typedef enum logic [10:0] {
    PH_MEAN  = 11'b00000000001,
    PH_NQ    = 11'b00000000010,
    PH_SS    = 11'b00000000100,
    PH_NN    = 11'b00000001000,
    PH_VAR   = 11'b00000010000,
    PH_SQRT  = 11'b00000100000,
    PH_WD    = 11'b00001000000,
    PH_GI    = 11'b00010000000,
    PH_TEMPO = 11'b00100000000,
    PH_U2    = 11'b01000000000,
    PH_U3    = 11'b10000000000
  } phase_t;

  function automatic phase_t ph_next(input phase_t p);
    phase_t r;
    unique case (p)
      PH_MEAN:  r = PH_NQ;
      PH_NQ:    r = PH_SS;
      PH_SS:    r = PH_NN;
      PH_NN:    r = PH_VAR;
      PH_VAR:   r = PH_SQRT;
      PH_SQRT:  r = PH_WD;
      PH_WD:    r = PH_GI;
      PH_GI:    r = PH_TEMPO;
      PH_TEMPO: r = PH_U2;
      PH_U2:    r = PH_U3;
      PH_U3:    r = PH_MEAN;
      default:  r = PH_MEAN;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/abt_if.sv
// ----------------------------------------------------------------------------
// abt_if: valid/ready channels of the adaptive beat tracker
// Input channel carries one frame level, output channel one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface abt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] low_level;
  modport source (output valid, output low_level, input ready);
  modport sink   (input valid, input low_level, output ready);
endinterface

interface abt_out_if;
  logic        valid;
  logic        ready;
  logic        beat;
  logic [15:0] envelope_shaped;
  logic [11:0] median_interval;
  logic [15:0] tempo_x16;
  logic [15:0] threshold_level;
  modport source (output valid, output beat, output envelope_shaped,
                  output median_interval, output tempo_x16,
                  output threshold_level, input ready);
  modport sink   (input valid, input beat, input envelope_shaped,
                  input median_interval, input tempo_x16,
                  input threshold_level, output ready);
endinterface

`default_nettype wire

>>> src/adaptive_beat_tracker.sv
// ----------------------------------------------------------------------------
// adaptive_beat_tracker: adaptive threshold beat detector with median tempo
// Window statistics, threshold test, envelope and interval median, computed
// by one bit-serial multiplier, one bit-serial divider and a serial root.
//
//   channel  | dir | transfer             | payload
//   in_ch    | in  | valid && ready       | low_level
//   out_ch   | out | valid && ready       | beat, envelope_shaped,
//            |     |                      | median_interval, tempo_x16,
//            |     |                      | threshold_level
//   cfg_*    | in  | cfg_we               | cfg_index, cfg_data
//
// A frame takes the window sum over the window length in use, three
// divisions (the tempo one only once a median is known), seven shift-add
// products (one cycle per multiplier bit) and a serial root. A frame that
// stores a new interval, once MIN_INTERVALS are held, adds a median scan.
// in_ch.ready is high only while no frame is at work; a finished result
// waits in the output register while the next frame is taken.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_beat_tracker #(
  parameter int HISTORY_DEPTH  = 64,
  parameter int INTERVAL_DEPTH = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  abt_in_if.sink                         in_ch,
  abt_out_if.source                      out_ch,
  input  wire                            cfg_we,
  input  wire [abt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [abt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import abt_pkg::*;

  localparam int HW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int NW  = $clog2(HISTORY_DEPTH + 1);
  localparam int SW  = 16 + NW;
  localparam int QW  = 32 + NW;
  localparam int IW  = (INTERVAL_DEPTH > 1) ? $clog2(INTERVAL_DEPTH) : 1;
  localparam int IFW = $clog2(INTERVAL_DEPTH + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SUM   = 11'b00000000010,
    S_NEXT  = 11'b00000000100,
    S_MUL   = 11'b00000001000,
    S_DIV   = 11'b00000010000,
    S_SQRT  = 11'b00000100000,
    S_DEC   = 11'b00001000000,
    S_MLD   = 11'b00010000000,
    S_MCAND = 11'b00100000000,
    S_MRUN  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r;
  phase_t phase_r;

  // configuration
  logic [6:0]  hist_len_r;
  logic [15:0] gain_r, weight_r, step_r, frame_rate_r;
  logic [11:0] min_int_r;

  // frame state
  logic [HW-1:0]  head_r;
  logic [NW-1:0]  fill_r;
  logic [11:0]    frames_r;
  logic           beat_seen_r;
  logic [15:0]    env_r;
  logic [IW-1:0]  ihead_r;
  logic [IFW-1:0] ifill_r;
  logic [11:0]    median_r;

  // memories
  logic [15:0] win_mem [HISTORY_DEPTH];
  logic [11:0] int_mem [INTERVAL_DEPTH];
  logic [15:0] win_rd_r;
  logic [11:0] int_rd_r;
  logic [HW-1:0] win_raddr;
  logic [IW-1:0] int_raddr;
  logic          win_we, int_we;

  // window sum
  logic [15:0]   level_r;
  logic [NW-1:0] n_r, cnt_r;
  logic [HW-1:0] ptr_r;
  logic          sv_r;
  logic [SW-1:0] s_r;
  logic [QW-1:0] q_r;

  // intermediate results
  logic [15:0]     mean_r, dev_r;
  logic [63:0]     nq_r, var_num_r;
  logic [2*NW-1:0] nn_r;
  logic [31:0]     var_r;
  logic [33:0]     inner_r, uu_r;
  logic [49:0]     prod_r;
  logic            trig_r;
  logic [15:0]     thr_r, shaped_r, tempo_r;

  // median scan
  logic [IFW-1:0] mi_r, mj_r;
  logic [IFW-1:0] lt_r, le_r;
  logic           mv_r;
  logic [11:0]    cand_r;

  // serial units
  logic [63:0] ma_r, macc_r, mstep;
  logic [31:0] mb_r;
  logic [63:0] dv_rem_r, dv_q_r, dv_d_r, rem_sh, rem_n, q_n;
  logic [5:0]  dv_cnt_r;
  logic        dv_ge;
  logic [31:0] sq_v_r, sq_res_r, sq_bit_r, sq_sum, sq_res_n, sq_v_n;
  logic        sq_ge;
  logic        unit_done;
  logic [63:0] unit_res;

  // output register
  logic        out_valid_r, o_beat_r;
  logic [15:0] o_shaped_r, o_tempo_r, o_thr_r;
  logic [11:0] o_median_r;

  // helpers
  logic           in_xfer, out_xfer;
  logic [HW-1:0]  head_nxt, ptr_dec;
  logic [NW-1:0]  fill_nxt, len_eff, n_nxt;
  logic           trig;
  logic           push;
  logic [15:0]    env_base, env_nxt;
  logic [IFW-1:0] ifill_nxt;
  logic [16:0]    u_val, ease_r17;
  logic [19:0]    fr15;
  logic [15:0]    thr_nxt;
  logic [IFW-1:0] kmid;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.beat            = o_beat_r;
  assign out_ch.envelope_shaped = o_shaped_r;
  assign out_ch.median_interval = o_median_r;
  assign out_ch.tempo_x16       = o_tempo_r;
  assign out_ch.threshold_level = o_thr_r;

  always_comb begin
    head_nxt = (32'(head_r) + 1 >= HISTORY_DEPTH) ? '0 : head_r + 1'b1;
    fill_nxt = (32'(fill_r) < HISTORY_DEPTH) ? fill_r + 1'b1 : fill_r;
    if (hist_len_r == '0) begin
      len_eff = NW'(1);
    end else if (32'(hist_len_r) > HISTORY_DEPTH) begin
      len_eff = NW'(HISTORY_DEPTH);
    end else begin
      len_eff = NW'(hist_len_r);
    end
    n_nxt   = (fill_nxt < len_eff) ? fill_nxt : len_eff;
    ptr_dec = (ptr_r == '0) ? HW'(HISTORY_DEPTH - 1) : ptr_r - 1'b1;
  end

  assign win_we    = in_xfer;
  assign win_raddr = ptr_dec;
  assign int_raddr = (state_r == S_MLD) ? mi_r[IW-1:0] : mj_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[head_r] <= in_ch.low_level;
    end
    win_rd_r <= win_mem[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (int_we) begin
      int_mem[ihead_r] <= frames_r;
    end
    int_rd_r <= int_mem[int_raddr];
  end

  // serial unit steps
  always_comb begin
    mstep  = macc_r + (mb_r[0] ? ma_r : 64'd0);
    rem_sh = {dv_rem_r[62:0], dv_q_r[63]};
    dv_ge  = (rem_sh >= dv_d_r);
    rem_n  = dv_ge ? rem_sh - dv_d_r : rem_sh;
    q_n    = {dv_q_r[62:0], dv_ge};
    sq_sum = sq_res_r + sq_bit_r;
    sq_ge  = (sq_v_r >= sq_sum);
    sq_v_n   = sq_ge ? sq_v_r - sq_sum : sq_v_r;
    sq_res_n = sq_ge ? (sq_res_r >> 1) + sq_bit_r : (sq_res_r >> 1);
    unit_done = 1'b0;
    unit_res  = 64'd0;
    unique case (state_r)
      S_MUL: begin
        unit_done = (mb_r[31:1] == '0);
        unit_res  = mstep;
      end
      S_DIV: begin
        unit_done = (dv_cnt_r == '0);
        unit_res  = q_n;
      end
      S_SQRT: begin
        unit_done = (sq_bit_r == 32'd1);
        unit_res  = {32'd0, sq_res_n};
      end
      default: begin
        unit_done = 1'b0;
      end
    endcase
  end

  // frame decision
  always_comb begin
    trig      = (frames_r >= min_int_r) && ({10'd0, level_r, 24'd0} > prod_r);
    push      = trig && beat_seen_r && (frames_r != '0);
    env_base  = trig ? 16'hFFFF : env_r;
    env_nxt   = (env_base > step_r) ? env_base - step_r : 16'd0;
    ifill_nxt = (32'(ifill_r) < INTERVAL_DEPTH) ? ifill_r + 1'b1 : ifill_r;
    thr_nxt   = (prod_r[49:40] != '0) ? 16'hFFFF : prod_r[39:24];
    u_val     = 17'h10000 - {1'b0, env_r};
    fr15      = {frame_rate_r, 4'd0} - {4'd0, frame_rate_r};
    ease_r17  = 17'h10000 - unit_res[48:32];
    kmid      = ifill_r >> 1;
  end

  assign int_we = (state_r == S_DEC) && push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_MEAN;
      hist_len_r   <= RST_HISTORY_LEN;
      gain_r       <= RST_THRESH_GAIN;
      weight_r     <= RST_DEV_WEIGHT;
      min_int_r    <= RST_MIN_INTERVAL;
      step_r       <= RST_ENV_STEP;
      frame_rate_r <= RST_FRAME_RATE;
      head_r       <= '0;
      fill_r       <= '0;
      frames_r     <= FRAMES_MAX;
      beat_seen_r  <= 1'b0;
      env_r        <= '0;
      ihead_r      <= '0;
      ifill_r      <= '0;
      median_r     <= '0;
      out_valid_r  <= 1'b0;
      sv_r         <= 1'b0;
      mv_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HISTORY_LEN:  hist_len_r   <= cfg_data[6:0];
          REG_THRESH_GAIN:  gain_r       <= cfg_data;
          REG_DEV_WEIGHT:   weight_r     <= cfg_data;
          REG_MIN_INTERVAL: min_int_r    <= cfg_data[11:0];
          REG_ENV_STEP:     step_r       <= cfg_data;
          REG_FRAME_RATE:   frame_rate_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_xfer && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            level_r  <= in_ch.low_level;
            frames_r <= (frames_r < FRAMES_MAX) ? frames_r + 1'b1 : frames_r;
            head_r   <= head_nxt;
            fill_r   <= fill_nxt;
            n_r      <= n_nxt;
            cnt_r    <= n_nxt;
            ptr_r    <= head_nxt;
            s_r      <= '0;
            q_r      <= '0;
            sv_r     <= 1'b0;
            state_r  <= S_SUM;
          end
        end
        S_SUM: begin
          if (cnt_r != '0) begin
            ptr_r <= ptr_dec;
            cnt_r <= cnt_r - 1'b1;
            sv_r  <= 1'b1;
          end else begin
            sv_r  <= 1'b0;
          end
          if (sv_r) begin
            s_r <= s_r + SW'(win_rd_r);
            q_r <= q_r + QW'(32'(win_rd_r) * 32'(win_rd_r));
          end
          if (cnt_r == '0 && !sv_r) begin
            phase_r <= PH_MEAN;
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          macc_r   <= '0;
          dv_rem_r <= '0;
          dv_cnt_r <= 6'd63;
          unique case (phase_r)
            PH_MEAN: begin
              dv_q_r <= 64'(s_r); dv_d_r <= 64'(n_r); state_r <= S_DIV;
            end
            PH_NQ: begin
              ma_r <= 64'(q_r); mb_r <= 32'(n_r); state_r <= S_MUL;
            end
            PH_SS: begin
              ma_r <= 64'(s_r); mb_r <= 32'(s_r); state_r <= S_MUL;
            end
            PH_NN: begin
              ma_r <= 64'(n_r); mb_r <= 32'(n_r); state_r <= S_MUL;
            end
            PH_VAR: begin
              dv_q_r <= var_num_r; dv_d_r <= 64'(nn_r); state_r <= S_DIV;
            end
            PH_SQRT: begin
              sq_v_r   <= var_r;
              sq_res_r <= '0;
              sq_bit_r <= 32'h4000_0000;
              state_r  <= S_SQRT;
            end
            PH_WD: begin
              ma_r <= 64'(dev_r); mb_r <= 32'(weight_r); state_r <= S_MUL;
            end
            PH_GI: begin
              ma_r <= 64'(inner_r); mb_r <= 32'(gain_r); state_r <= S_MUL;
            end
            PH_TEMPO: begin
              if (median_r == '0) begin
                tempo_r <= '0;
                phase_r <= PH_U2;
              end else begin
                dv_q_r  <= 64'(fr15);
                dv_d_r  <= 64'({median_r, 2'b00});
                state_r <= S_DIV;
              end
            end
            PH_U2: begin
              ma_r <= 64'(u_val); mb_r <= 32'(u_val); state_r <= S_MUL;
            end
            PH_U3: begin
              ma_r <= 64'(uu_r); mb_r <= 32'(u_val); state_r <= S_MUL;
            end
            default: state_r <= S_NEXT;
          endcase
        end
        S_MUL, S_DIV, S_SQRT: begin
          macc_r   <= mstep;
          ma_r     <= ma_r << 1;
          mb_r     <= mb_r >> 1;
          dv_rem_r <= rem_n;
          dv_q_r   <= q_n;
          dv_cnt_r <= dv_cnt_r - 1'b1;
          sq_v_r   <= sq_v_n;
          sq_res_r <= sq_res_n;
          sq_bit_r <= sq_bit_r >> 2;
          if (unit_done) begin
            unique case (phase_r)
              PH_MEAN:  mean_r    <= unit_res[15:0];
              PH_NQ:    nq_r      <= unit_res;
              PH_SS:    var_num_r <= nq_r - unit_res;
              PH_NN:    nn_r      <= unit_res[2*NW-1:0];
              PH_VAR:   var_r     <= unit_res[31:0];
              PH_SQRT:  dev_r     <= unit_res[15:0];
              PH_WD:    inner_r   <= {2'b00, 4'd0, mean_r, 12'd0} + unit_res[33:0];
              PH_GI:    prod_r    <= unit_res[49:0];
              PH_TEMPO: tempo_r   <= (unit_res[63:16] != '0) ? 16'hFFFF
                                                             : unit_res[15:0];
              PH_U2:    uu_r      <= unit_res[33:0];
              PH_U3:    shaped_r  <= ease_r17[16] ? 16'hFFFF : ease_r17[15:0];
              default: ;
            endcase
            phase_r <= ph_next(phase_r);
            if (phase_r == PH_GI) begin
              state_r <= S_DEC;
            end else if (phase_r == PH_U3) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_NEXT;
            end
          end
        end
        S_DEC: begin
          trig_r <= trig;
          thr_r  <= thr_nxt;
          env_r  <= env_nxt;
          if (trig) begin
            beat_seen_r <= 1'b1;
            frames_r    <= '0;
          end
          if (push) begin
            ihead_r <= (32'(ihead_r) + 1 >= INTERVAL_DEPTH) ? '0 : ihead_r + 1'b1;
            ifill_r <= ifill_nxt;
          end
          phase_r <= PH_TEMPO;
          if (push && 32'(ifill_nxt) >= MIN_INTERVALS) begin
            mi_r    <= '0;
            state_r <= S_MLD;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_MLD: begin
          state_r <= S_MCAND;
        end
        S_MCAND: begin
          cand_r  <= int_rd_r;
          mj_r    <= '0;
          lt_r    <= '0;
          le_r    <= '0;
          mv_r    <= 1'b0;
          state_r <= S_MRUN;
        end
        S_MRUN: begin
          if (mj_r != ifill_r) begin
            mj_r <= mj_r + 1'b1;
            mv_r <= 1'b1;
          end else begin
            mv_r <= 1'b0;
          end
          if (mv_r) begin
            lt_r <= lt_r + IFW'(int_rd_r < cand_r);
            le_r <= le_r + IFW'(int_rd_r <= cand_r);
          end
          if (mj_r == ifill_r && !mv_r) begin
            if (lt_r <= kmid && kmid < le_r) begin
              median_r <= cand_r;
              state_r  <= S_NEXT;
            end else begin
              mi_r    <= mi_r + 1'b1;
              state_r <= S_MLD;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            o_beat_r    <= trig_r;
            o_shaped_r  <= shaped_r;
            o_median_r  <= median_r;
            o_tempo_r   <= tempo_r;
            o_thr_r     <= thr_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/abt_checker.sv
// ----------------------------------------------------------------------------
// abt_checker: port-level checks of the adaptive beat tracker
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module abt_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        beat,
  input wire [15:0] envelope_shaped,
  input wire [11:0] median_interval,
  input wire [15:0] tempo_x16,
  input wire [15:0] threshold_level
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(beat) &&
      $stable(envelope_shaped) && $stable(median_interval) &&
      $stable(tempo_x16) && $stable(threshold_level))
    else $error("stalled result changed");

  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second frame taken while one is at work");

  a_beat_thr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && beat |-> threshold_level != 16'hFFFF)
    else $error("beat above a saturated threshold");

  a_tempo_med: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tempo_x16 != 16'd0 |-> median_interval != 12'd0)
    else $error("tempo without a median interval");

endmodule

bind adaptive_beat_tracker abt_checker u_abt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .beat            (out_ch.beat),
  .envelope_shaped (out_ch.envelope_shaped),
  .median_interval (out_ch.median_interval),
  .tempo_x16       (out_ch.tempo_x16),
  .threshold_level (out_ch.threshold_level)
);

`default_nettype wire
